[hdl/rfv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfv_pkg: shared types and constants of the RTCM3 frame validator
// Holds the item and result records, sequencer states and the CRC-24Q step.
// ----------------------------------------------------------------------------
package rfv_pkg;

    localparam int DEFAULT_DEPTH  = 4096;
    localparam logic [7:0]  PREAMBLE = 8'hD3;
    localparam logic [24:0] CRC_POLY = 25'h1864CFB;
    localparam logic [7:0]  LEN_HI_MASK = 8'h03;
    localparam int MIN_SCAN       = 6;
    localparam int MIN_HEADER     = 3;
    localparam int FRAME_OVERHEAD = 6;
    localparam int HEADER_BYTES   = 3;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [31:0] dropped;
        logic        overflow;
        logic [15:0] crc_errors;
        logic [23:0] last_expected;
        logic [23:0] last_actual;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PULL_RD,
        ST_PULL_OUT,
        ST_PUSH,
        ST_LAST_RD,
        ST_LAST_CK,
        ST_OVF_NOPRE,
        ST_OVF_CHK,
        ST_WRITE,
        ST_SCAN_TOP,
        ST_FIND_RD,
        ST_FIND_CK,
        ST_LEN_CHK,
        ST_LEN_RD1,
        ST_LEN_RD2,
        ST_LEN_CK,
        ST_CRC_RD,
        ST_CRC_CK,
        ST_EXP_RD,
        ST_EXP_CK,
        ST_CRC_CMP,
        ST_MARK,
        ST_DROP_CHK,
        ST_DROP_RD,
        ST_DROP_WR,
        ST_DROP_END,
        ST_RESULT
    } t_state;

    // CRC-24Q update by one byte, MSB first.
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc,
                                                input logic [7:0] b);
        logic [23:0] c;
        logic        top;
        c = crc ^ {b, 16'h0000};
        for (int n = 0; n < 8; n++) begin
            top = c[23];
            c = {c[22:0], 1'b0};
            if (top) begin
                c = c ^ CRC_POLY[23:0];
            end
        end
        return c;
    endfunction

endpackage

[hdl/rtcm3_frame_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcm3_frame_validator: RTCM3 deframer with CRC-24Q check
// Buffers received bytes, validates frames and reads released frames out.
// ----------------------------------------------------------------------------
// Usage: each request on the slave stream is either a push (tuser[0] = 0,
// tdata = received byte) or a pull (tuser[0] = 1). Every request yields
// exactly one response on the master stream carrying the pulled byte, if
// any, plus the drop, overflow and CRC error status.
// Sequencing: a pull of a stored byte passes the read, output and result
// states. A push checks for a full buffer, writes the byte and then runs
// the frame scan, which walks the buffer memory through its single read
// port with a read and a check state per byte for preamble search and CRC
// and a check, read and write state per byte for byte shifting; a rejected
// preamble is dropped by shifting every pending byte down.
// A two-entry request queue accepts new requests while the engine works.
// Reset clears all pointers, counters and flags at once; no clearing pass
// is needed. When the receiver stalls, the response register holds, the
// engine waits after finishing its request and the queue then fills.
// ----------------------------------------------------------------------------
module rtcm3_frame_validator import rfv_pkg::*; #(
    parameter int BUFFER_DEPTH = DEFAULT_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]   i_s_axis_tuser,   // [0] op
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [7:0] out_byte, [39:8] dropped_bytes, [40] overflow_seen,
    // [56:41] crc_errors, [80:57] last_expected_crc,
    // [104:81] last_actual_crc, [111:105] zero
    output logic [111:0] o_m_axis_tdata,
    output logic [1:0]   o_m_axis_tuser,   // [0] out_valid, [1] out_first
    output logic         o_m_axis_tlast    // out_last
);

    logic    w_item_valid;
    t_item   w_item;
    logic    w_pop;
    t_result w_res;

    rfv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_op         (i_s_axis_tuser[0]),
        .i_data       (i_s_axis_tdata),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    rfv_engine #(.DEPTH(BUFFER_DEPTH)) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_res_valid  (o_m_axis_tvalid),
        .o_res        (w_res),
        .i_res_ready  (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {7'b0, w_res.last_actual, w_res.last_expected,
                             w_res.crc_errors, w_res.overflow, w_res.dropped,
                             w_res.data};
    assign o_m_axis_tuser = {w_res.first, w_res.valid};
    assign o_m_axis_tlast = w_res.last;

endmodule

[hdl/rfv_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfv_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rfv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/rfv_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfv_front: request intake
// Accepts push and pull requests into a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module rfv_front import rfv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic [7:0] i_data,
    output logic       o_item_valid,
    output t_item      o_item,
    input  logic       i_pop
);

    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_item      w_item;

    assign o_ready      = (r_cnt != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_pop && (r_cnt != 2'd0);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rd];

    // Classify the request; a pull carries no byte.
    always_comb begin
        w_item.op   = i_op ? OP_PULL : OP_PUSH;
        w_item.data = i_op ? 8'h00 : i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_mem[r_wr] <= w_item;
                r_wr        <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

[hdl/rfv_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfv_engine: ring buffer, frame scanner and readout
// Executes one request at a time over the byte and end-mark memories.
// ----------------------------------------------------------------------------
module rfv_engine import rfv_pkg::*; #(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic [7:0]    r_v, n_v;
    logic [AW-1:0] r_rp, n_rp;
    logic [AW-1:0] r_ps, n_ps;
    logic [CW-1:0] r_rc, n_rc;
    logic [CW-1:0] r_pc, n_pc;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_last_pre, n_last_pre;
    logic          r_found, n_found;
    logic [9:0]    r_len, n_len;
    logic [1:0]    r_len_hi, n_len_hi;
    logic [23:0]   r_crc, n_crc;
    logic [23:0]   r_exp, n_exp;
    logic          r_next_first, n_next_first;
    logic [31:0]   r_drop, n_drop;
    logic [15:0]   r_crc_err, n_crc_err;
    logic          r_ovf, n_ovf;
    logic [23:0]   r_last_exp, n_last_exp;
    logic [23:0]   r_last_act, n_last_act;
    logic          r_res_valid, n_res_valid;
    logic [7:0]    r_res_byte, n_res_byte;
    logic          r_res_first, n_res_first;
    logic          r_res_last, n_res_last;
    t_result       r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          w_byte_we;
    logic [AW-1:0] w_byte_waddr;
    logic [7:0]    w_byte_wdata;
    logic [AW-1:0] w_byte_raddr;
    logic [7:0]    w_byte_rdata;
    logic          w_mark_we;
    logic [AW-1:0] w_mark_waddr;
    logic          w_mark_wdata;
    logic          w_mark_rdata;

    logic          w_full;
    logic [CW:0]   w_ik;
    logic [CW-1:0] w_len_ext;
    logic [CW-1:0] w_flen;
    logic [9:0]    w_len_new;
    logic [32:0]   w_drop_sum;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [AW:0] s;
        s = (AW+1)'(base) + (AW+1)'(off);
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    rfv_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_bytes (
        .i_clk   (i_clk),
        .i_we    (w_byte_we),
        .i_waddr (w_byte_waddr),
        .i_wdata (w_byte_wdata),
        .i_raddr (w_byte_raddr),
        .o_rdata (w_byte_rdata)
    );

    rfv_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_marks (
        .i_clk   (i_clk),
        .i_we    (w_mark_we),
        .i_waddr (w_mark_waddr),
        .i_wdata (w_mark_wdata),
        .i_raddr (r_rp),
        .o_rdata (w_mark_rdata)
    );

    assign w_full     = ((CW+1)'(r_rc) + (CW+1)'(r_pc)) >= (CW+1)'(DEPTH);
    assign w_ik       = (CW+1)'(r_i) + (CW+1)'(r_k);
    assign w_len_ext  = CW'(r_len);
    assign w_flen     = w_len_ext + CW'(FRAME_OVERHEAD);
    assign w_len_new  = {r_len_hi, w_byte_rdata};
    assign w_drop_sum = {1'b0, r_drop} + 33'(r_k);

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_v          = r_v;
        n_rp         = r_rp;
        n_ps         = r_ps;
        n_rc         = r_rc;
        n_pc         = r_pc;
        n_i          = r_i;
        n_k          = r_k;
        n_last_pre   = r_last_pre;
        n_found      = r_found;
        n_len        = r_len;
        n_len_hi     = r_len_hi;
        n_crc        = r_crc;
        n_exp        = r_exp;
        n_next_first = r_next_first;
        n_drop       = r_drop;
        n_crc_err    = r_crc_err;
        n_ovf        = r_ovf;
        n_last_exp   = r_last_exp;
        n_last_act   = r_last_act;
        n_res_valid  = r_res_valid;
        n_res_byte   = r_res_byte;
        n_res_first  = r_res_first;
        n_res_last   = r_res_last;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        o_pop        = 1'b0;
        w_byte_we    = 1'b0;
        w_byte_waddr = f_slot(r_ps, r_i);
        w_byte_wdata = r_v;
        w_byte_raddr = f_slot(r_ps, r_i);
        w_mark_we    = 1'b0;
        w_mark_waddr = f_slot(r_ps, r_i);
        w_mark_wdata = (r_i + CW'(1)) == w_flen;

        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop       = 1'b1;
                    n_v         = i_item.data;
                    n_res_valid = 1'b0;
                    n_res_byte  = 8'h00;
                    n_res_first = 1'b0;
                    n_res_last  = 1'b0;
                    if (i_item.op == OP_PUSH) begin
                        n_state = ST_PUSH;
                    end else if (r_rc != '0) begin
                        n_state = ST_PULL_RD;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_PULL_RD: begin
                // Memories present the byte and mark at the read pointer.
                w_byte_raddr = r_rp;
                n_state      = ST_PULL_OUT;
            end
            ST_PULL_OUT: begin
                n_res_valid  = 1'b1;
                n_res_byte   = w_byte_rdata;
                n_res_first  = r_next_first;
                n_res_last   = w_mark_rdata;
                n_next_first = w_mark_rdata;
                n_rp         = f_slot(r_rp, CW'(1));
                n_rc         = r_rc - CW'(1);
                n_state      = ST_RESULT;
            end
            ST_PUSH: begin
                if (w_full) begin
                    n_ovf = 1'b1;
                    n_i   = '0;
                    if (r_v == PREAMBLE) begin
                        n_k     = r_pc;
                        n_ret   = ST_OVF_CHK;
                        n_state = ST_DROP_CHK;
                    end else begin
                        n_found = 1'b0;
                        n_state = ST_LAST_RD;
                    end
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_LAST_RD: begin
                if (r_i == r_pc) begin
                    n_i = '0;
                    if (r_found) begin
                        n_k   = r_last_pre;
                        n_ret = ST_OVF_CHK;
                    end else begin
                        n_k   = r_pc;
                        n_ret = ST_OVF_NOPRE;
                    end
                    n_state = ST_DROP_CHK;
                end else begin
                    n_state = ST_LAST_CK;
                end
            end
            ST_LAST_CK: begin
                if (w_byte_rdata == PREAMBLE) begin
                    n_last_pre = r_i;
                    n_found    = 1'b1;
                end
                n_i     = r_i + CW'(1);
                n_state = ST_LAST_RD;
            end
            ST_OVF_NOPRE: begin
                if (r_drop != '1) begin
                    n_drop = r_drop + 32'd1;
                end
                n_state = ST_RESULT;
            end
            ST_OVF_CHK: begin
                if (w_full) begin
                    if (r_drop != '1) begin
                        n_drop = r_drop + 32'd1;
                    end
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                w_byte_we    = 1'b1;
                w_byte_waddr = f_slot(r_ps, r_pc);
                n_pc         = r_pc + CW'(1);
                n_state      = ST_SCAN_TOP;
            end
            ST_SCAN_TOP: begin
                n_i = '0;
                if (r_pc < CW'(MIN_SCAN)) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_FIND_RD;
                end
            end
            ST_FIND_RD: begin
                if (r_i == r_pc) begin
                    // No preamble pending: everything goes.
                    n_k     = r_pc;
                    n_i     = '0;
                    n_ret   = ST_RESULT;
                    n_state = ST_DROP_CHK;
                end else begin
                    n_state = ST_FIND_CK;
                end
            end
            ST_FIND_CK: begin
                if (w_byte_rdata == PREAMBLE) begin
                    if (r_i == '0) begin
                        n_state = ST_LEN_CHK;
                    end else begin
                        n_k     = r_i;
                        n_i     = '0;
                        n_ret   = ST_LEN_CHK;
                        n_state = ST_DROP_CHK;
                    end
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = ST_FIND_RD;
                end
            end
            ST_LEN_CHK: begin
                n_i = CW'(1);
                if (r_pc < CW'(MIN_HEADER)) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_LEN_RD1;
                end
            end
            ST_LEN_RD1: begin
                n_i     = CW'(2);
                n_state = ST_LEN_RD2;
            end
            ST_LEN_RD2: begin
                n_len_hi = w_byte_rdata[1:0] & LEN_HI_MASK[1:0];
                n_state  = ST_LEN_CK;
            end
            ST_LEN_CK: begin
                n_i = '0;
                if (w_len_new == '0) begin
                    n_k     = CW'(1);
                    n_ret   = ST_SCAN_TOP;
                    n_state = ST_DROP_CHK;
                end else if (r_pc < CW'(w_len_new) + CW'(FRAME_OVERHEAD)) begin
                    n_state = ST_RESULT;
                end else begin
                    n_len   = w_len_new;
                    n_crc   = '0;
                    n_state = ST_CRC_RD;
                end
            end
            ST_CRC_RD: begin
                n_state = ST_CRC_CK;
            end
            ST_CRC_CK: begin
                n_crc = crc24q_byte(r_crc, w_byte_rdata);
                n_i   = r_i + CW'(1);
                if (r_i + CW'(1) == w_len_ext + CW'(HEADER_BYTES)) begin
                    n_state = ST_EXP_RD;
                end else begin
                    n_state = ST_CRC_RD;
                end
            end
            ST_EXP_RD: begin
                n_state = ST_EXP_CK;
            end
            ST_EXP_CK: begin
                n_exp = {r_exp[15:0], w_byte_rdata};
                n_i   = r_i + CW'(1);
                if (r_i + CW'(1) == w_flen) begin
                    n_state = ST_CRC_CMP;
                end else begin
                    n_state = ST_EXP_RD;
                end
            end
            ST_CRC_CMP: begin
                n_i = '0;
                if (r_exp != r_crc) begin
                    if (r_crc_err != '1) begin
                        n_crc_err = r_crc_err + 16'd1;
                    end
                    n_last_exp = r_exp;
                    n_last_act = r_crc;
                    n_k        = CW'(1);
                    n_ret      = ST_SCAN_TOP;
                    n_state    = ST_DROP_CHK;
                end else begin
                    n_state = ST_MARK;
                end
            end
            ST_MARK: begin
                // Release the frame: one end mark per byte, set on the last.
                w_mark_we = 1'b1;
                n_i       = r_i + CW'(1);
                if (r_i + CW'(1) == w_flen) begin
                    n_rc    = r_rc + w_flen;
                    n_pc    = r_pc - w_flen;
                    n_ps    = f_slot(r_ps, w_flen);
                    n_state = ST_SCAN_TOP;
                end
            end
            ST_DROP_CHK: begin
                if (w_ik < (CW+1)'(r_pc)) begin
                    n_state = ST_DROP_RD;
                end else begin
                    n_state = ST_DROP_END;
                end
            end
            ST_DROP_RD: begin
                w_byte_raddr = f_slot(r_ps, w_ik[CW-1:0]);
                n_state      = ST_DROP_WR;
            end
            ST_DROP_WR: begin
                // Shift the pending bytes down so they stay contiguous.
                w_byte_we    = 1'b1;
                w_byte_wdata = w_byte_rdata;
                n_i          = r_i + CW'(1);
                n_state      = ST_DROP_CHK;
            end
            ST_DROP_END: begin
                n_pc    = r_pc - r_k;
                n_drop  = w_drop_sum[32] ? '1 : w_drop_sum[31:0];
                n_state = r_ret;
            end
            ST_RESULT: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid         = 1'b1;
                    n_out.valid         = r_res_valid;
                    n_out.data          = r_res_byte;
                    n_out.first         = r_res_first;
                    n_out.last          = r_res_last;
                    n_out.dropped       = r_drop;
                    n_out.overflow      = r_ovf;
                    n_out.crc_errors    = r_crc_err;
                    n_out.last_expected = r_last_exp;
                    n_out.last_actual   = r_last_act;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ret        <= ST_IDLE;
            r_rp         <= '0;
            r_ps         <= '0;
            r_rc         <= '0;
            r_pc         <= '0;
            r_i          <= '0;
            r_k          <= '0;
            r_found      <= 1'b0;
            r_crc        <= '0;
            r_next_first <= 1'b1;
            r_drop       <= '0;
            r_crc_err    <= '0;
            r_ovf        <= 1'b0;
            r_last_exp   <= '0;
            r_last_act   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_rp         <= n_rp;
            r_ps         <= n_ps;
            r_rc         <= n_rc;
            r_pc         <= n_pc;
            r_i          <= n_i;
            r_k          <= n_k;
            r_found      <= n_found;
            r_crc        <= n_crc;
            r_next_first <= n_next_first;
            r_drop       <= n_drop;
            r_crc_err    <= n_crc_err;
            r_ovf        <= n_ovf;
            r_last_exp   <= n_last_exp;
            r_last_act   <= n_last_act;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v         <= n_v;
        r_last_pre  <= n_last_pre;
        r_len       <= n_len;
        r_len_hi    <= n_len_hi;
        r_exp       <= n_exp;
        r_res_valid <= n_res_valid;
        r_res_byte  <= n_res_byte;
        r_res_first <= n_res_first;
        r_res_last  <= n_res_last;
        r_out       <= n_out;
    end

endmodule

[hdl/rfv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfv_checker: port-level checks of the RTCM3 frame validator
// Watches the response stream for flag consistency and monotonic status.
// ----------------------------------------------------------------------------
module rfv_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [7:0]   i_s_axis_tdata,
    input logic [0:0]   i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [111:0] o_m_axis_tdata,
    input logic [1:0]   o_m_axis_tuser,
    input logic         o_m_axis_tlast
);

    logic        r_seen;
    logic [31:0] r_prev_drop;
    logic [15:0] r_prev_err;
    logic        r_prev_ovf;
    logic        w_take;

    assign w_take = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_prev_drop <= '0;
            r_prev_err  <= '0;
            r_prev_ovf  <= 1'b0;
        end else if (w_take) begin
            r_seen      <= 1'b1;
            r_prev_drop <= o_m_axis_tdata[39:8];
            r_prev_err  <= o_m_axis_tdata[56:41];
            r_prev_ovf  <= o_m_axis_tdata[40];
        end
    end

    // A response without a byte carries no marks and a zero byte.
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |->
        (!o_m_axis_tlast && !o_m_axis_tuser[1] && o_m_axis_tdata[7:0] == 8'h00))
        else $error("response without byte carries marks or data");

    // Saturating counters never step back between responses.
    a_counts_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_seen) |->
        (o_m_axis_tdata[39:8] >= r_prev_drop && o_m_axis_tdata[56:41] >= r_prev_err))
        else $error("status counter decreased");

    // The overflow flag is sticky.
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_prev_ovf) |-> o_m_axis_tdata[40])
        else $error("overflow flag cleared");

    // A stalled response holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled response changed");

endmodule

bind rtcm3_frame_validator rfv_checker u_rfv_checker (.*);

[bench/rtcm3_frame_validator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcm3_frame_validator_tb: self-checking bench of the RTCM3 frame validator
// Drives push and pull requests on the slave stream with random idles and
// checks every response against a behavioral predictor of the deframer.
// ----------------------------------------------------------------------------
module rtcm3_frame_validator_tb;
    import rfv_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;

    function automatic bit [23:0] crc24_add(bit [23:0] c, bit [7:0] b);
        bit [24:0] r;
        r = {1'b0, c ^ {b, 16'h0000}};
        for (int n = 0; n < 8; n++) begin
            r = r << 1;
            if (r[24]) r = r ^ CRC_POLY;
        end
        return r[23:0];
    endfunction

    // Predicts the deframer: ring store, frame scan and status counters.
    class rfv_scoreboard;
        bit [7:0]    store [DEPTH];
        bit          end_mark [DEPTH];
        int unsigned rd_ptr, p_start, rel_cnt, pend_cnt;
        bit          next_first;
        int unsigned dropped;
        int unsigned crc_errs;
        bit          ovf;
        bit [23:0]   lexp, lact;
        t_result     expq [$];
        int          errors;
        int          checked;
        int          frames_out;

        function void clear();
            rd_ptr = 0; p_start = 0; rel_cnt = 0; pend_cnt = 0;
            next_first = 1; dropped = 0; crc_errs = 0; ovf = 0;
            lexp = 0; lact = 0; errors = 0; checked = 0; frames_out = 0;
        endfunction

        function int unsigned slot(int unsigned i);
            return (p_start + i) % DEPTH;
        endfunction

        function void add_dropped(int unsigned n);
            longint unsigned s;
            s = longint'(dropped) + n;
            dropped = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void drop_front(int unsigned k);
            if (k > pend_cnt) k = pend_cnt;
            for (int unsigned i = 0; i + k < pend_cnt; i++)
                store[slot(i)] = store[slot(i + k)];
            pend_cnt -= k;
            add_dropped(k);
        endfunction

        function void scan();
            int unsigned k, len, flen, crc_exp;
            bit [23:0]   crc;
            while (pend_cnt >= 6) begin
                k = 0;
                while (k < pend_cnt && store[slot(k)] != PREAMBLE) k++;
                if (k == pend_cnt) begin
                    drop_front(pend_cnt);
                    break;
                end
                if (k > 0) drop_front(k);
                if (pend_cnt < 3) break;
                len = {store[slot(1)][1:0], store[slot(2)]};
                if (len == 0) begin
                    drop_front(1);
                    continue;
                end
                flen = len + 6;
                if (pend_cnt < flen) break;
                crc = 0;
                for (int unsigned i = 0; i < len + 3; i++)
                    crc = crc24_add(crc, store[slot(i)]);
                crc_exp = {store[slot(len + 3)], store[slot(len + 4)],
                           store[slot(len + 5)]};
                if (crc_exp != crc) begin
                    if (crc_errs < 16'hFFFF) crc_errs++;
                    lexp = 24'(crc_exp);
                    lact = crc;
                    drop_front(1);
                    continue;
                end
                for (int unsigned i = 0; i < flen; i++)
                    end_mark[slot(i)] = (i + 1 == flen);
                rel_cnt += flen;
                pend_cnt -= flen;
                p_start = slot(flen);
            end
        endfunction

        function void push(bit [7:0] v);
            int unsigned last_pre;
            bit          found;
            if (rel_cnt + pend_cnt >= DEPTH) begin
                ovf = 1;
                if (v == PREAMBLE) begin
                    drop_front(pend_cnt);
                end else begin
                    found = 0;
                    last_pre = 0;
                    for (int unsigned i = 0; i < pend_cnt; i++)
                        if (store[slot(i)] == PREAMBLE) begin
                            last_pre = i;
                            found = 1;
                        end
                    if (!found) begin
                        drop_front(pend_cnt);
                        add_dropped(1);
                        return;
                    end
                    drop_front(last_pre);
                end
                if (rel_cnt + pend_cnt >= DEPTH) begin
                    add_dropped(1);
                    return;
                end
            end
            store[slot(pend_cnt)] = v;
            pend_cnt++;
            scan();
        endfunction

        // Notes one accepted request and queues the response it must cause.
        function void note_request(t_op op, bit [7:0] v);
            t_result r;
            r = '0;
            if (op == OP_PUSH) begin
                push(v);
            end else if (rel_cnt > 0) begin
                r.valid = 1;
                r.data  = store[rd_ptr];
                r.first = next_first;
                r.last  = end_mark[rd_ptr];
                next_first = r.last;
                rd_ptr = (rd_ptr + 1) % DEPTH;
                rel_cnt--;
                p_start = (rd_ptr + rel_cnt) % DEPTH;
            end
            r.dropped       = dropped;
            r.overflow      = ovf;
            r.crc_errors    = 16'(crc_errs);
            r.last_expected = lexp;
            r.last_actual   = lact;
            expq.push_back(r);
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %0d: %s got %0h expected %0h", checked, what, got, want);
        endfunction

        function void check_result(t_result got);
            t_result w;
            if (expq.size() == 0) begin
                report("unexpected response", 1, 0);
                return;
            end
            w = expq.pop_front();
            if (got.valid != w.valid) report("out_valid", got.valid, w.valid);
            if (got.data != w.data) report("out_byte", got.data, w.data);
            if (got.first != w.first) report("out_first", got.first, w.first);
            if (got.last != w.last) report("out_last", got.last, w.last);
            if (got.dropped != w.dropped) report("dropped_bytes", got.dropped, w.dropped);
            if (got.overflow != w.overflow) report("overflow_seen", got.overflow, w.overflow);
            if (got.crc_errors != w.crc_errors)
                report("crc_errors", got.crc_errors, w.crc_errors);
            if (got.last_expected != w.last_expected)
                report("last_expected_crc", got.last_expected, w.last_expected);
            if (got.last_actual != w.last_actual)
                report("last_actual_crc", got.last_actual, w.last_actual);
            if (w.valid && w.last) frames_out++;
            checked++;
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_valid = 0;
    logic [7:0]   s_data = 0;
    logic [0:0]   s_user = 0;
    logic         m_ready = 0;
    logic         s_ready;
    logic         m_valid;
    logic [111:0] m_data;  // [7:0] byte, [39:8] dropped, [40] overflow, [56:41] crc errors,
                           // [80:57] expected crc, [104:81] actual crc
    logic [1:0]   m_user;  // [0] out_valid, [1] out_first
    logic         m_last;

    bit           quiet = 0;
    int           n_items = 0;
    int           n_frames = 0;
    rfv_scoreboard sb;

    rtcm3_frame_validator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        m_ready <= (!quiet && $urandom_range(99) < 27) ? 1'b0 : 1'b1;
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_valid && m_ready) begin
            got.valid         = m_user[0];
            got.first         = m_user[1];
            got.last          = m_last;
            got.data          = m_data[7:0];
            got.dropped       = m_data[39:8];
            got.overflow      = m_data[40];
            got.crc_errors    = m_data[56:41];
            got.last_expected = m_data[80:57];
            got.last_actual   = m_data[104:81];
            sb.check_result(got);
        end
    end

    task automatic send(t_op op, bit [7:0] v);
        if (!quiet && $urandom_range(99) < 27) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_valid <= 1;
        s_data  <= v;
        s_user  <= op;
        do @(posedge i_clk); while (!s_ready);
        sb.note_request(op, v);
        n_items++;
    endtask

    task automatic push_byte(bit [7:0] v);
        send(OP_PUSH, v);
    endtask

    task automatic pull_byte();
        send(OP_PULL, 8'($urandom_range(255)));
    endtask

    // Sends a frame with the given payload length; a nonzero flip corrupts
    // the CRC, and a short cut truncates the frame.
    task automatic push_frame(int len, bit [23:0] flip, int cut, int pull_pct);
        bit [7:0]  bytes [$];
        bit [23:0] crc;
        bytes = {};
        bytes.push_back(PREAMBLE);
        bytes.push_back({6'($urandom_range(63)), 2'(len >> 8)});
        bytes.push_back(8'(len));
        for (int i = 0; i < len; i++) bytes.push_back(8'($urandom_range(255)));
        crc = 0;
        foreach (bytes[i]) crc = crc24_add(crc, bytes[i]);
        crc ^= flip;
        bytes.push_back(crc[23:16]);
        bytes.push_back(crc[15:8]);
        bytes.push_back(crc[7:0]);
        for (int i = 0; i < bytes.size() - cut; i++) begin
            push_byte(bytes[i]);
            if ($urandom_range(99) < pull_pct) pull_byte();
        end
        n_frames++;
    endtask

    task automatic drain();
        while (sb.rel_cnt > 0) pull_byte();
        pull_byte();
    endtask

    task automatic wait_settled();
        while (sb.expq.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        #100ms;
        $display("[rtcm3_frame_validator] ERROR");
        $finish;
    end

    initial begin
        int kind;
        bit paused;
        sb = new;
        sb.clear();
        paused = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty pull, noise without preamble, zero length, good and bad CRC.
        pull_byte();
        repeat (6) push_byte(8'h00);
        repeat (6) push_byte(8'hFF);
        push_byte(PREAMBLE); push_byte(8'hFC); push_byte(8'h00);
        push_byte(8'h12); push_byte(8'h34); push_byte(8'h56);
        push_frame(1, 0, 0, 0);
        push_frame(2, 24'h000001, 0, 0);
        push_frame(3, 24'h800000, 0, 0);
        drain();

        while (n_items < 1250) begin
            quiet = (n_items > 400 && n_items < 700);
            kind = $urandom_range(99);
            if (kind < 60)
                push_frame($urandom_range(1, 24), 0, 0, 30);
            else if (kind < 72)
                push_frame($urandom_range(1, 24), 24'($urandom_range(1, 24'hFFFFFF)),
                           0, 30);
            else if (kind < 78)
                push_frame($urandom_range(4, 24), 0, $urandom_range(1, 4), 20);
            else if (kind < 88)
                repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(255)));
            else
                repeat ($urandom_range(1, 10)) pull_byte();
            if (!paused && n_items > 900) begin
                paused = 1;
                s_valid <= 0;
                wait_settled();
                repeat (200) @(posedge i_clk);
            end
        end
        drain();

        s_valid <= 0;
        wait_settled();
        repeat (100) @(posedge i_clk);
        $display("covered %0d requests, %0d frames sent, %0d frames read back, %0d responses",
                 n_items, n_frames, sb.frames_out, sb.checked);
        $display("dropped %0d bytes, %0d CRC errors, overflow %0b",
                 sb.dropped, sb.crc_errs, sb.ovf);
        if (sb.errors == 0 && sb.expq.size() == 0) begin
            $display("[rtcm3_frame_validator] OK");
        end else begin
            $display("[rtcm3_frame_validator] ERROR");
        end
        $finish;
    end

endmodule
